// ===== hdl/timestamp_unwrap_gps_align_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp unwrap core
// Same-cycle and next-cycle implication checks on the core clock and reset.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_UNWRAP_GPS_ALIGN_CORE_ASSERT_SVH
`define TIMESTAMP_UNWRAP_GPS_ALIGN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsu: next-cycle check failed");

`endif

// ===== hdl/tsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp unwrap package
// Widths, register indexes, reset values, sequencer states and divider types.
// ----------------------------------------------------------------------------
package tsu_pkg;

    localparam int CFG_W      = 40;
    localparam int CHAN_W     = 8;
    localparam int LIMIT_W    = 32;
    localparam int EXT_W      = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int TIME_BITS_DEF = 40;

    // Shared divider operand widths.
    localparam int DVD_W      = 64;
    localparam int DVS_W      = CFG_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_CHANNEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 3'd4;

    localparam logic [CFG_W-1:0]   RST_WRAP_PERIOD   = 40'd1000000;
    localparam logic [CFG_W-1:0]   RST_SECOND_LENGTH = 40'd1000000000000;
    localparam logic [CFG_W-1:0]   RST_EARLY_WINDOW  = 40'd1000000;
    localparam logic [CHAN_W-1:0]  RST_GPS_CHANNEL   = 8'd0;
    localparam logic [LIMIT_W-1:0] RST_SEARCH_LIMIT  = 32'd400000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV_K,
        S_DIV_R,
        S_DIV_B,
        S_GCD_ISSUE,
        S_GCD_WAIT,
        S_DIV_PER,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/timestamp_unwrap_gps_align_core.sv =====
// ----------------------------------------------------------------------------
// Timestamp unwrap with GPS pulse alignment
// Extends wrapping raw times with a running carry and aligns GPS pulses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  input   | in        | i_valid / o_stall | i_channel, i_raw_time
//  output  | out       | o_valid / i_stall | o_channel_out, o_extended_time,
//          |           |                   | o_is_gps, o_gps_found, o_gps_time
//  config  | in        | i_cfg_we          | i_cfg_index, i_cfg_data
//
// A non-GPS request lands in the output register at the edge after it is taken;
// such requests can follow each other every cycle while the output is not stalled.
// A GPS request runs four divisions on the shared 64-step divider (three when the
// raw time already lies after the last pulse), plus one per Euclid step of
// gcd(second, wrap % second), then a residue scan of N candidates, at most
// min(search_limit - kmin, second / gcd), or min(search_limit, second / gcd) when
// the raw time lies after the last pulse. A search cut short ends sooner.
// Reset is synchronous and loads the register defaults; there is no clearing pass.
// The result sits in an output register; a new request is taken only when that
// register is empty or its result leaves in the same cycle.
// ----------------------------------------------------------------------------
module timestamp_unwrap_gps_align_core #(
    parameter int TIME_BITS = tsu_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tsu_pkg::CHAN_W-1:0]    i_channel,
    input  logic [TIME_BITS-1:0]          i_raw_time,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tsu_pkg::CHAN_W-1:0]    o_channel_out,
    output logic [tsu_pkg::EXT_W-1:0]     o_extended_time,
    output logic                          o_is_gps,
    output logic                          o_gps_found,
    output logic [tsu_pkg::EXT_W-1:0]     o_gps_time,
    input  logic                          i_cfg_we,
    input  logic [tsu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsu_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = tsu_pkg::CFG_W;
    localparam int EW = tsu_pkg::EXT_W;
    localparam int DW = tsu_pkg::DVD_W;
    localparam int LW = tsu_pkg::LIMIT_W;
    localparam int HW = tsu_pkg::CHAN_W;

    // Control state.
    tsu_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_wrap, n_wrap;
    logic [CW-1:0]  r_second, n_second;
    logic [CW-1:0]  r_window, n_window;
    logic [HW-1:0]  r_gps_id, n_gps_id;
    logic [LW-1:0]  r_limit, n_limit;
    logic [EW-1:0]  r_carry, n_carry;
    logic [TIME_BITS-1:0] r_prev, n_prev;
    logic [EW-1:0]  r_last, n_last;
    logic           r_o_valid, n_o_valid;

    // Payload and search registers.
    logic [TIME_BITS-1:0] r_raw, n_raw;
    logic [HW-1:0]  r_chan, n_chan;
    logic [EW-1:0]  r_ext, n_ext;
    logic           r_found, n_found;
    logic [CW-1:0]  r_res, n_res;
    logic [CW-1:0]  r_b, n_b;
    logic [CW-1:0]  r_ga, n_ga;
    logic [CW-1:0]  r_gb, n_gb;
    logic [EW-1:0]  r_cand, n_cand;
    logic [LW-1:0]  r_left, n_left;
    logic [HW-1:0]  r_o_chan, n_o_chan;
    logic [EW-1:0]  r_o_ext, n_o_ext;
    logic           r_o_is_gps, n_o_is_gps;
    logic           r_o_found, n_o_found;
    logic [EW-1:0]  r_o_gps_time, n_o_gps_time;

    tsu_pkg::t_div_req div_req;
    tsu_pkg::t_div_rsp div_rsp;

    logic           in_accept;
    logic           out_free;
    logic           in_is_gps;
    logic [EW-1:0]  carry_up;
    logic [EW-1:0]  ext_in;
    logic [CW-1:0]  s_eff;
    logic [CW-1:0]  half;
    logic [DW-1:0]  raw64;
    logic [DW-1:0]  last64;
    logic           raw_gt_last;
    logic [DW-1:0]  kmin;
    logic           kmin_ge;
    logic [CW-1:0]  p_minus_rem;
    logic           hit;
    logic [CW:0]    res_sum;
    logic [CW-1:0]  res_next;

    tsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free  = !r_o_valid || !i_stall;
    assign o_stall   = (r_state != tsu_pkg::S_IDLE) || !out_free;
    assign in_accept = i_valid && !o_stall;
    assign in_is_gps = i_channel == r_gps_id;

    assign carry_up = (i_raw_time < r_prev) ? r_carry + EW'(r_wrap) : r_carry;
    assign ext_in   = EW'(i_raw_time) + carry_up;

    // A zero second length behaves as a second of one unit.
    assign s_eff = (r_second == '0) ? CW'(1) : r_second;
    assign half  = s_eff >> 1;

    assign raw64       = DW'(r_raw);
    assign last64      = DW'(r_last);
    assign raw_gt_last = raw64 > last64;
    assign kmin        = div_rsp.quot + DW'(1);
    assign kmin_ge     = kmin >= DW'(r_limit);
    assign p_minus_rem = r_wrap - div_rsp.rem;

    // The gap residue is centered around zero: above half it stands for res - second.
    always_comb begin
        if (r_res > half) begin
            hit = ({1'b0, r_res} + {1'b0, r_window}) > {1'b0, s_eff};
        end else begin
            hit = ((r_res != '0) || (r_window != '0)) && (r_res < r_wrap);
        end
    end

    assign res_sum  = {1'b0, r_res} + {1'b0, r_b};
    assign res_next = (res_sum >= {1'b0, s_eff}) ? CW'(res_sum - {1'b0, s_eff})
                                                 : res_sum[CW-1:0];

    always_comb begin
        n_state      = r_state;
        n_wrap       = r_wrap;
        n_second     = r_second;
        n_window     = r_window;
        n_gps_id     = r_gps_id;
        n_limit      = r_limit;
        n_carry      = r_carry;
        n_prev       = r_prev;
        n_last       = r_last;
        n_o_valid    = r_o_valid;
        n_raw        = r_raw;
        n_chan       = r_chan;
        n_ext        = r_ext;
        n_found      = r_found;
        n_res        = r_res;
        n_b          = r_b;
        n_ga         = r_ga;
        n_gb         = r_gb;
        n_cand       = r_cand;
        n_left       = r_left;
        n_o_chan     = r_o_chan;
        n_o_ext      = r_o_ext;
        n_o_is_gps   = r_o_is_gps;
        n_o_found    = r_o_found;
        n_o_gps_time = r_o_gps_time;
        div_req      = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsu_pkg::CFG_WRAP_PERIOD:   n_wrap   = i_cfg_data;
                tsu_pkg::CFG_SECOND_LENGTH: n_second = i_cfg_data;
                tsu_pkg::CFG_EARLY_WINDOW:  n_window = i_cfg_data;
                tsu_pkg::CFG_GPS_CHANNEL:   n_gps_id = i_cfg_data[HW-1:0];
                tsu_pkg::CFG_SEARCH_LIMIT:  n_limit  = i_cfg_data[LW-1:0];
                default: ;
            endcase
        end

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            tsu_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_prev = i_raw_time;
                    if (in_is_gps) begin
                        n_carry = '0;
                        n_raw   = i_raw_time;
                        n_chan  = i_channel;
                        n_ext   = ext_in;
                        n_found = 1'b0;
                        n_state = tsu_pkg::S_START;
                    end else begin
                        n_carry      = carry_up;
                        n_o_valid    = 1'b1;
                        n_o_chan     = i_channel;
                        n_o_ext      = ext_in;
                        n_o_is_gps   = 1'b0;
                        n_o_found    = 1'b0;
                        n_o_gps_time = r_last;
                    end
                end
            end
            tsu_pkg::S_START: begin
                if (raw_gt_last) begin
                    // The raw time itself already lies after the last GPS time.
                    if (r_limit == '0) begin
                        n_state = tsu_pkg::S_DONE;
                    end else begin
                        n_left           = r_limit;
                        n_cand           = EW'(r_raw);
                        div_req.start    = 1'b1;
                        div_req.dividend = raw64 - last64;
                        div_req.divisor  = s_eff;
                        n_state          = tsu_pkg::S_DIV_R;
                    end
                end else if (r_wrap == '0) begin
                    n_state = tsu_pkg::S_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = last64 - raw64;
                    div_req.divisor  = r_wrap;
                    n_state          = tsu_pkg::S_DIV_K;
                end
            end
            tsu_pkg::S_DIV_K: begin
                if (div_rsp.done) begin
                    if (kmin_ge) begin
                        n_state = tsu_pkg::S_DONE;
                    end else begin
                        // First candidate is last + (period - remainder).
                        n_left           = r_limit - kmin[LW-1:0];
                        n_cand           = r_last + EW'(p_minus_rem);
                        div_req.start    = 1'b1;
                        div_req.dividend = DW'(p_minus_rem);
                        div_req.divisor  = s_eff;
                        n_state          = tsu_pkg::S_DIV_R;
                    end
                end
            end
            tsu_pkg::S_DIV_R: begin
                if (div_rsp.done) begin
                    n_res            = div_rsp.rem;
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(r_wrap);
                    div_req.divisor  = s_eff;
                    n_state          = tsu_pkg::S_DIV_B;
                end
            end
            tsu_pkg::S_DIV_B: begin
                if (div_rsp.done) begin
                    n_b     = div_rsp.rem;
                    n_ga    = s_eff;
                    n_gb    = div_rsp.rem;
                    n_state = tsu_pkg::S_GCD_ISSUE;
                end
            end
            tsu_pkg::S_GCD_ISSUE: begin
                div_req.start = 1'b1;
                if (r_gb == '0) begin
                    // The residues repeat after second / gcd steps.
                    div_req.dividend = DW'(s_eff);
                    div_req.divisor  = r_ga;
                    n_state          = tsu_pkg::S_DIV_PER;
                end else begin
                    div_req.dividend = DW'(r_ga);
                    div_req.divisor  = r_gb;
                    n_state          = tsu_pkg::S_GCD_WAIT;
                end
            end
            tsu_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    n_ga    = r_gb;
                    n_gb    = div_rsp.rem;
                    n_state = tsu_pkg::S_GCD_ISSUE;
                end
            end
            tsu_pkg::S_DIV_PER: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot < DW'(r_left)) begin
                        n_left = div_rsp.quot[LW-1:0];
                    end
                    n_state = tsu_pkg::S_SCAN;
                end
            end
            tsu_pkg::S_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_last  = r_cand;
                    n_state = tsu_pkg::S_DONE;
                end else if (r_left == LW'(1)) begin
                    n_state = tsu_pkg::S_DONE;
                end else begin
                    n_res  = res_next;
                    n_cand = r_cand + EW'(r_wrap);
                    n_left = r_left - LW'(1);
                end
            end
            tsu_pkg::S_DONE: begin
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_chan     = r_chan;
                    n_o_ext      = r_ext;
                    n_o_is_gps   = 1'b1;
                    n_o_found    = r_found;
                    n_o_gps_time = r_last;
                    n_state      = tsu_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsu_pkg::S_IDLE;
            r_wrap    <= tsu_pkg::RST_WRAP_PERIOD;
            r_second  <= tsu_pkg::RST_SECOND_LENGTH;
            r_window  <= tsu_pkg::RST_EARLY_WINDOW;
            r_gps_id  <= tsu_pkg::RST_GPS_CHANNEL;
            r_limit   <= tsu_pkg::RST_SEARCH_LIMIT;
            r_carry   <= '0;
            r_prev    <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wrap    <= n_wrap;
            r_second  <= n_second;
            r_window  <= n_window;
            r_gps_id  <= n_gps_id;
            r_limit   <= n_limit;
            r_carry   <= n_carry;
            r_prev    <= n_prev;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw        <= n_raw;
        r_chan       <= n_chan;
        r_ext        <= n_ext;
        r_found      <= n_found;
        r_res        <= n_res;
        r_b          <= n_b;
        r_ga         <= n_ga;
        r_gb         <= n_gb;
        r_cand       <= n_cand;
        r_left       <= n_left;
        r_o_chan     <= n_o_chan;
        r_o_ext      <= n_o_ext;
        r_o_is_gps   <= n_o_is_gps;
        r_o_found    <= n_o_found;
        r_o_gps_time <= n_o_gps_time;
    end

    assign o_valid         = r_o_valid;
    assign o_channel_out   = r_o_chan;
    assign o_extended_time = r_o_ext;
    assign o_is_gps        = r_o_is_gps;
    assign o_gps_found     = r_o_found;
    assign o_gps_time      = r_o_gps_time;

`include "timestamp_unwrap_gps_align_core_assert.svh"

    `TSU_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy)
    `TSU_ASSERT_SAME(a_scan_left, r_state == tsu_pkg::S_SCAN, r_left != '0)
    `TSU_ASSERT_SAME(a_plain_no_gps, o_valid && !o_is_gps, !o_gps_found)
    `TSU_ASSERT_NEXT(a_plain_lands, in_accept && !in_is_gps, o_valid)

endmodule

// ===== hdl/tsu_div.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; quotient and remainder held after done.
// ----------------------------------------------------------------------------
module tsu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsu_pkg::t_div_req i_req,
    output tsu_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [tsu_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [tsu_pkg::DVD_W-1:0]       r_q;
    logic [tsu_pkg::DVS_W-1:0]       r_rem;
    logic [tsu_pkg::DVS_W-1:0]       r_dvs;

    logic [tsu_pkg::DVS_W:0]         rem_sh;
    logic [tsu_pkg::DVS_W:0]         rem_sub;
    logic                            ge;
    logic                            last_bit;

    assign rem_sh   = {r_rem, r_q[tsu_pkg::DVD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_dvs};
    assign ge       = rem_sh >= {1'b0, r_dvs};
    assign last_bit = r_cnt == tsu_pkg::DIV_CNT_W'(tsu_pkg::DVD_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last_bit;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_bit) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[tsu_pkg::DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[tsu_pkg::DVS_W-1:0] : rem_sh[tsu_pkg::DVS_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule
